// File: design/rcrf_pkg.sv
// Shared constants and controller/datapath handshake types for the refcount table.
package rcrf_pkg;

    localparam int ID_W    = 32;
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    localparam logic [1:0] CMD_REF   = 2'd0;
    localparam logic [1:0] CMD_REL   = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_NOREF = 2'd2;
    localparam logic [1:0] STATUS_OVF   = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic scan_run;
        logic update;
        logic shift_run;
        logic finish;
    } rcrf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic need_shift;
        logic shift_done;
    } rcrf_stat_t;

endpackage

// File: design/rcrf_ctrl.sv
// Sequencing state machine for the refcount table: scan, update, FIFO shift, result.
module rcrf_ctrl
    import rcrf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  logic       m_ready,
    input  rcrf_stat_t dp_stat,
    output rcrf_cmd_t  dp_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_SHIFT,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        dp_cmd       = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    dp_cmd.load = 1'b1;
                    state_next  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                dp_cmd.scan_run = 1'b1;
                if (dp_stat.scan_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                dp_cmd.update = 1'b1;
                state_next    = dp_stat.need_shift ? ST_SHIFT : ST_FINISH;
            end
            ST_SHIFT: begin
                dp_cmd.shift_run = 1'b1;
                if (dp_stat.shift_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                // hold until the previous result has been taken
                if (!m_valid_reg || m_ready) begin
                    dp_cmd.finish = 1'b1;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

// File: design/rcrf_dpath.sv
// Datapath: key/count table memory, recent-release FIFO memory, scan and result registers.
module rcrf_dpath
    import rcrf_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int RECENT_DEPTH  = 8,
    parameter int IDENT_BITS    = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  rcrf_cmd_t          dp_cmd,
    output rcrf_stat_t         dp_stat,
    input  logic [1:0]         s_command,
    input  logic [ID_W-1:0]    s_ident,
    output logic [1:0]         m_status,
    output logic               m_evicted_valid,
    output logic [ID_W-1:0]    m_evicted_ident,
    output logic               m_watched,
    output logic [COUNT_W-1:0] m_ref_count
);

    localparam int KEY_W = (IDENT_BITS < ID_W) ? IDENT_BITS : ID_W;
    localparam int TA_W  = $clog2(TABLE_ENTRIES);
    localparam int TP_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int FA_W  = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
    localparam int FP_W  = $clog2(RECENT_DEPTH + 1);
    localparam int TW    = COUNT_W + KEY_W;

    // Memories
    logic [TW-1:0]    tbl_mem  [TABLE_ENTRIES];
    logic [KEY_W-1:0] fifo_mem [RECENT_DEPTH];
    logic [TW-1:0]    tbl_rd_reg;
    logic [KEY_W-1:0] fifo_rd_reg;

    // Request and scan state
    logic [1:0]               cmd_reg;
    logic [KEY_W-1:0]         id_reg;
    logic [TABLE_ENTRIES-1:0] used_reg, used_next;
    logic [TP_W-1:0]          t_ptr_reg, t_ptr_next;
    logic                     t_vld_reg;
    logic [TA_W-1:0]          t_idx_reg;
    logic [FP_W-1:0]          f_ptr_reg, f_ptr_next;
    logic                     f_vld_reg;
    logic [FA_W-1:0]          f_idx_reg;
    logic [FP_W-1:0]          fill_reg, fill_next;
    logic                     hit_reg, free_reg, ff_hit_reg;
    logic [TA_W-1:0]          hit_idx_reg, free_idx_reg;
    logic [COUNT_W-1:0]       hit_cnt_reg;
    logic [FA_W-1:0]          ff_pos_reg;
    logic [KEY_W-1:0]         head_reg;

    // Result registers
    logic [1:0]         status_reg;
    logic               ev_valid_reg;
    logic [ID_W-1:0]    ev_ident_reg;
    logic               watched_reg;
    logic [COUNT_W-1:0] count_reg;

    // Decision
    logic               is_ref, is_rel, changed, fifo_full, evict, need_shift;
    logic [1:0]         status_c;
    logic [COUNT_W-1:0] res_cnt;
    logic [TA_W-1:0]    tbl_waddr;
    logic [FA_W-1:0]    shift_start;
    logic [FP_W-1:0]    app_ptr;
    logic               t_rd_en, f_rd_en;
    logic [KEY_W-1:0]   t_key;
    logic [COUNT_W-1:0] t_cnt;

    assign t_key = tbl_rd_reg[KEY_W-1:0];
    assign t_cnt = tbl_rd_reg[TW-1:KEY_W];

    always_comb begin
        is_ref = (cmd_reg == CMD_REF);
        is_rel = (cmd_reg == CMD_REL);
        status_c = STATUS_OK;
        if (is_ref) begin
            if (!hit_reg && !free_reg) begin
                status_c = STATUS_FULL;
            end else if (hit_reg && hit_cnt_reg == COUNT_MAX) begin
                status_c = STATUS_OVF;
            end
        end else if (is_rel && !hit_reg) begin
            status_c = STATUS_NOREF;
        end
        changed = (is_ref || is_rel) && (status_c == STATUS_OK);

        priority if (is_ref) begin
            if (status_c == STATUS_OK) begin
                res_cnt = hit_reg ? hit_cnt_reg + COUNT_W'(1) : COUNT_W'(1);
            end else if (status_c == STATUS_OVF) begin
                res_cnt = hit_cnt_reg;
            end else begin
                res_cnt = '0;
            end
        end else if (is_rel) begin
            res_cnt = (changed && hit_cnt_reg > COUNT_W'(1)) ? hit_cnt_reg - COUNT_W'(1) : '0;
        end else begin
            res_cnt = hit_reg ? hit_cnt_reg : '0;
        end

        fifo_full   = (fill_reg == FP_W'(RECENT_DEPTH));
        evict       = changed && is_rel && !ff_hit_reg && fifo_full;
        need_shift  = changed && (ff_hit_reg || evict);
        shift_start = ff_hit_reg ? ff_pos_reg : '0;
        tbl_waddr   = hit_reg ? hit_idx_reg : free_idx_reg;
        app_ptr     = need_shift ? fill_reg - FP_W'(1) : fill_reg;

        t_rd_en = dp_cmd.scan_run && (t_ptr_reg != TP_W'(TABLE_ENTRIES));
        f_rd_en = (dp_cmd.scan_run || dp_cmd.shift_run) && (f_ptr_reg < fill_reg);

        priority if (dp_cmd.load) begin
            t_ptr_next = '0;
        end else if (t_rd_en) begin
            t_ptr_next = t_ptr_reg + TP_W'(1);
        end else begin
            t_ptr_next = t_ptr_reg;
        end

        priority if (dp_cmd.load) begin
            f_ptr_next = '0;
        end else if (dp_cmd.update) begin
            // shift reads start one slot past the removed one
            f_ptr_next = FP_W'(shift_start) + FP_W'(1);
        end else if (f_rd_en) begin
            f_ptr_next = f_ptr_reg + FP_W'(1);
        end else begin
            f_ptr_next = f_ptr_reg;
        end

        used_next = used_reg;
        if (dp_cmd.update && changed) begin
            used_next[tbl_waddr] = (res_cnt != '0);
        end

        fill_next = fill_reg;
        if (dp_cmd.finish && changed) begin
            if (is_rel && !need_shift) begin
                fill_next = fill_reg + FP_W'(1);
            end else if (is_ref && need_shift) begin
                fill_next = fill_reg - FP_W'(1);
            end
        end
    end

    assign dp_stat.scan_done  = (t_ptr_reg == TP_W'(TABLE_ENTRIES)) && !t_vld_reg &&
                                (f_ptr_reg >= fill_reg) && !f_vld_reg;
    assign dp_stat.need_shift = need_shift;
    assign dp_stat.shift_done = (f_ptr_reg >= fill_reg) && !f_vld_reg;

    // Table memory: one read, one write port
    always_ff @(posedge aclk) begin
        if (t_rd_en) begin
            tbl_rd_reg <= tbl_mem[t_ptr_reg[TA_W-1:0]];
        end
        if (dp_cmd.update && changed) begin
            tbl_mem[tbl_waddr] <= {res_cnt, id_reg};
        end
    end

    // FIFO memory: shift writes move a slot down, the append lands at the tail
    always_ff @(posedge aclk) begin
        if (f_rd_en) begin
            fifo_rd_reg <= fifo_mem[f_ptr_reg[FA_W-1:0]];
        end
        priority if (dp_cmd.shift_run && f_vld_reg) begin
            fifo_mem[f_idx_reg - FA_W'(1)] <= fifo_rd_reg;
        end else if (dp_cmd.finish && changed && is_rel) begin
            fifo_mem[app_ptr[FA_W-1:0]] <= id_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg   <= '0;
            fill_reg   <= '0;
            t_ptr_reg  <= '0;
            f_ptr_reg  <= '0;
            t_vld_reg  <= 1'b0;
            f_vld_reg  <= 1'b0;
            hit_reg    <= 1'b0;
            free_reg   <= 1'b0;
            ff_hit_reg <= 1'b0;
            cmd_reg    <= CMD_QUERY;
        end else begin
            used_reg  <= used_next;
            fill_reg  <= fill_next;
            t_ptr_reg <= t_ptr_next;
            f_ptr_reg <= f_ptr_next;
            t_vld_reg <= t_rd_en;
            f_vld_reg <= f_rd_en;
            if (dp_cmd.load) begin
                cmd_reg    <= s_command;
                hit_reg    <= 1'b0;
                free_reg   <= 1'b0;
                ff_hit_reg <= 1'b0;
            end else begin
                if (t_vld_reg) begin
                    if (used_reg[t_idx_reg] && t_key == id_reg) begin
                        hit_reg <= 1'b1;
                    end
                    if (!used_reg[t_idx_reg] && !free_reg) begin
                        free_reg <= 1'b1;
                    end
                end
                if (dp_cmd.scan_run && f_vld_reg && fifo_rd_reg == id_reg) begin
                    ff_hit_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (dp_cmd.load) begin
            id_reg <= s_ident[KEY_W-1:0];
        end
        if (t_rd_en) begin
            t_idx_reg <= t_ptr_reg[TA_W-1:0];
        end
        if (f_rd_en) begin
            f_idx_reg <= f_ptr_reg[FA_W-1:0];
        end
        if (t_vld_reg && !dp_cmd.load) begin
            if (used_reg[t_idx_reg] && t_key == id_reg) begin
                hit_idx_reg <= t_idx_reg;
                hit_cnt_reg <= t_cnt;
            end
            if (!used_reg[t_idx_reg] && !free_reg) begin
                free_idx_reg <= t_idx_reg;
            end
        end
        if (dp_cmd.scan_run && f_vld_reg) begin
            if (fifo_rd_reg == id_reg) begin
                ff_pos_reg <= f_idx_reg;
            end
            if (f_idx_reg == '0) begin
                head_reg <= fifo_rd_reg;
            end
        end
        if (dp_cmd.finish) begin
            status_reg   <= status_c;
            ev_valid_reg <= evict;
            ev_ident_reg <= evict ? ID_W'(head_reg) : '0;
            watched_reg  <= hit_reg || ff_hit_reg || changed;
            count_reg    <= res_cnt;
        end
    end

    assign m_status        = status_reg;
    assign m_evicted_valid = ev_valid_reg;
    assign m_evicted_ident = ev_ident_reg;
    assign m_watched       = watched_reg;
    assign m_ref_count     = count_reg;

endmodule

// File: design/refcount_table_with_recent_release_fifo.sv
// Top level: reference-count table with recent-release FIFO, controller plus datapath.
// Each request (reference, release or query of an identifier) is handled alone and
// gives one result. The time from one accepted request to the next is set by the
// linear search of the table memory, one entry per cycle, with the FIFO search run
// alongside. When an identifier leaves the FIFO, the slots behind it are compacted
// through the single read and write port of the FIFO memory, so such a request takes
// longer. The result sits in an output register, so the next request is taken while
// it waits. Its own result is held back until the previous one has been taken.
module refcount_table_with_recent_release_fifo
    import rcrf_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16,
    parameter int RECENT_DEPTH  = 8,
    parameter int IDENT_BITS    = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_command,
    input  logic [ID_W-1:0]    s_ident,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic               m_evicted_valid,
    output logic [ID_W-1:0]    m_evicted_ident,
    output logic               m_watched,
    output logic [COUNT_W-1:0] m_ref_count
);

    rcrf_cmd_t  dp_cmd;
    rcrf_stat_t dp_stat;

    rcrf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .dp_stat (dp_stat),
        .dp_cmd  (dp_cmd)
    );

    rcrf_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .RECENT_DEPTH  (RECENT_DEPTH),
        .IDENT_BITS    (IDENT_BITS)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .dp_cmd          (dp_cmd),
        .dp_stat         (dp_stat),
        .s_command       (s_command),
        .s_ident         (s_ident),
        .m_status        (m_status),
        .m_evicted_valid (m_evicted_valid),
        .m_evicted_ident (m_evicted_ident),
        .m_watched       (m_watched),
        .m_ref_count     (m_ref_count)
    );

    // A result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.finish |-> (!m_valid || m_ready))
        else $error("result overwritten while pending");

    // Busy right after a request is taken
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while busy");

    // An eviction only comes from a successful release, which leaves the id watched
    a_evict_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_evicted_valid) |-> (m_status == STATUS_OK && m_watched))
        else $error("eviction reported with bad status");

endmodule

// File: tb/tb_refcount_table_with_recent_release_fifo.sv
`timescale 1ns / 100ps
// Self-checking testbench for the reference-count table with recent-release FIFO.
module tb_refcount_table_with_recent_release_fifo;
    import rcrf_pkg::*;

    localparam int TABLE_ENTRIES = 16;
    localparam int RECENT_DEPTH  = 8;
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int POOL_SIZE     = 24;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 40;

    typedef struct packed {
        logic [1:0]      cmd;
        logic [ID_W-1:0] id;
    } request_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               evicted_valid;
        logic [ID_W-1:0]    evicted_ident;
        logic               watched;
        logic [COUNT_W-1:0] ref_count;
    } outcome_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_command = CMD_QUERY;
    logic [ID_W-1:0]    s_ident = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_status;
    logic               m_evicted_valid;
    logic [ID_W-1:0]    m_evicted_ident;
    logic               m_watched;
    logic [COUNT_W-1:0] m_ref_count;

    request_t pending_reqs[$];
    outcome_t expected_outcomes[$];
    request_t issue_req;
    outcome_t want;

    // Shadow copy of the table and the recent-release FIFO (front is oldest)
    logic [ID_W-1:0]    key_mem[TABLE_ENTRIES];
    logic [COUNT_W-1:0] count_mem[TABLE_ENTRIES];
    logic               used_mem[TABLE_ENTRIES] = '{default: 1'b0};
    logic [ID_W-1:0]    released_ids[$];

    logic [ID_W-1:0] id_pool[POOL_SIZE];
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_served   = 0;
    int hold_left      = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;

    always #2 aclk = ~aclk;

    refcount_table_with_recent_release_fifo #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .RECENT_DEPTH (RECENT_DEPTH),
        .IDENT_BITS   (ID_W)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_ident        (s_ident),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_evicted_valid(m_evicted_valid),
        .m_evicted_ident(m_evicted_ident),
        .m_watched      (m_watched),
        .m_ref_count    (m_ref_count)
    );

    function automatic int find_entry(input logic [ID_W-1:0] id);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (used_mem[i] && key_mem[i] == id) return i;
        end
        return -1;
    endfunction

    function automatic void drop_recent(input logic [ID_W-1:0] id);
        for (int i = 0; i < released_ids.size(); i++) begin
            if (released_ids[i] == id) begin
                released_ids.delete(i);
                return;
            end
        end
    endfunction

    function automatic outcome_t predict_outcome(input request_t req);
        outcome_t o;
        int slot;
        o = '0;
        slot = find_entry(req.id);
        if (req.cmd == CMD_REF) begin
            if (slot < 0) begin
                // take the lowest free entry
                for (int i = 0; i < TABLE_ENTRIES && slot < 0; i++) begin
                    if (!used_mem[i]) slot = i;
                end
                if (slot < 0) begin
                    o.status = STATUS_FULL;
                end else begin
                    used_mem[slot] = 1'b1;
                    key_mem[slot] = req.id;
                    count_mem[slot] = COUNT_W'(1);
                    drop_recent(req.id);
                end
            end else if (count_mem[slot] == COUNT_MAX) begin
                o.status = STATUS_OVF;
            end else begin
                count_mem[slot]++;
                drop_recent(req.id);
            end
        end else if (req.cmd == CMD_REL) begin
            if (slot < 0) begin
                o.status = STATUS_NOREF;
            end else begin
                if (count_mem[slot] <= 1) begin
                    used_mem[slot] = 1'b0;
                    count_mem[slot] = '0;
                end else begin
                    count_mem[slot]--;
                end
                // move to the tail, evicting the oldest when full
                drop_recent(req.id);
                if (released_ids.size() >= RECENT_DEPTH) begin
                    o.evicted_valid = 1'b1;
                    o.evicted_ident = released_ids.pop_front();
                end
                released_ids.push_back(req.id);
            end
        end
        slot = find_entry(req.id);
        o.watched = (slot >= 0);
        o.ref_count = (slot >= 0) ? count_mem[slot] : '0;
        foreach (released_ids[i]) begin
            if (released_ids[i] == req.id) o.watched = 1'b1;
        end
        return o;
    endfunction

    task automatic check_field(input string name, input logic [ID_W-1:0] exp_v,
                               input logic [ID_W-1:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, got_v);
            error_count++;
        end
    endtask

    // Driver: issue pending requests, predict each one as it is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                expected_outcomes.push_back(predict_outcome(request_t'{s_command, s_ident}));
            end
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                issue_req = pending_reqs.pop_front();
                s_valid   <= 1'b1;
                s_command <= issue_req.cmd;
                s_ident   <= issue_req.id;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver ready, with a long hold-off whenever one is requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_requests != holds_served) begin
            holds_served <= holds_served + 1;
            hold_left <= HOLD_CYCLES;
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_outcomes.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual status %0d count %0d",
                         $time, m_status, m_ref_count);
                error_count++;
            end else begin
                want = expected_outcomes.pop_front();
                check_field("status", ID_W'(want.status), ID_W'(m_status));
                check_field("evicted_valid", ID_W'(want.evicted_valid),
                            ID_W'(m_evicted_valid));
                check_field("evicted_ident", want.evicted_ident, m_evicted_ident);
                check_field("watched", ID_W'(want.watched), ID_W'(m_watched));
                check_field("ref_count", ID_W'(want.ref_count), ID_W'(m_ref_count));
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_req(input logic [1:0] cmd, input logic [ID_W-1:0] id);
        pending_reqs.push_back(request_t'{cmd, id});
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (pending_reqs.size() != 0 || s_valid || expected_outcomes.size() != 0)
            @(negedge aclk);
    endtask

    task automatic add_random(input int count, input int pool_hi);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                // noise: unknown identifier, never referenced
                add_req(2'($urandom_range(1, 3)), $urandom());
            end else if (pick < 48) begin
                add_req(CMD_REF, id_pool[$urandom_range(pool_hi)]);
            end else if (pick < 84) begin
                add_req(CMD_REL, id_pool[$urandom_range(pool_hi)]);
            end else if (pick < 94) begin
                add_req(CMD_QUERY, id_pool[$urandom_range(pool_hi)]);
            end else begin
                add_req(CMD_SPARE, id_pool[$urandom_range(pool_hi)]);
            end
        end
    endtask

    task automatic run_phase(input int send_pct, input int stall_pct, input int count,
                             input int pool_hi);
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        add_random(count, pool_hi);
        wait_drained();
    endtask

    initial begin
        foreach (id_pool[i]) id_pool[i] = $urandom();
        id_pool[0] = '0;
        id_pool[1] = '1;
        id_pool[2] = 32'h8000_0001;
        id_pool[5] = id_pool[4] ^ 32'h0000_0001;
        id_pool[6] = id_pool[4] ^ 32'h8000_0000;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: absent id, query alias, double release with re-append, table full
        add_req(CMD_QUERY, id_pool[0]);
        add_req(CMD_REL, id_pool[0]);
        add_req(CMD_REF, id_pool[0]);
        add_req(CMD_REF, id_pool[0]);
        add_req(CMD_SPARE, id_pool[0]);
        add_req(CMD_REL, id_pool[0]);
        add_req(CMD_REL, id_pool[0]);
        add_req(CMD_QUERY, id_pool[0]);
        add_req(CMD_REF, id_pool[0]);
        for (int i = 1; i <= TABLE_ENTRIES; i++) add_req(CMD_REF, id_pool[i]);
        wait_drained();

        run_phase(0, 0, 110, POOL_SIZE - 1);
        run_phase(50, 0, 110, 11);
        run_phase(0, 50, 110, POOL_SIZE - 1);
        run_phase(31, 31, 110, POOL_SIZE - 1);

        // Back up the block behind a stalled receiver
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests = hold_requests + 1;
        add_random(60, POOL_SIZE - 1);
        wait_drained();

        // Empty the table
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (used_mem[i]) repeat (count_mem[i]) add_req(CMD_REL, key_mem[i]);
        end
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/rcrf_pkg.sv
design/rcrf_ctrl.sv
design/rcrf_dpath.sv
design/refcount_table_with_recent_release_fifo.sv
tb/tb_refcount_table_with_recent_release_fifo.sv
